// ----- rtl/ldiv64_pkg.sv -----
// Shared widths, command codes and stage types of the 64-by-32 divider.
package ldiv64_pkg;

   localparam int DIVIDEND_W = 64;
   localparam int DIVISOR_W  = 32;
   localparam int QUOT_W     = 32;
   localparam int REM_W      = DIVISOR_W + 2;
   localparam int CELLS      = DIVIDEND_W;

   // Number of quotient bits that the result range is judged against.
   localparam int STEPS = 32;

   localparam logic [DIVIDEND_W-1:0] LIM_UNSIGNED =
      (64'd1 << STEPS) - 64'd1;
   localparam logic [DIVIDEND_W-1:0] LIM_SIGNED = 64'd1 << (STEPS - 1);

   localparam logic CMD_SIGNED   = 1'b0;
   localparam logic CMD_UNSIGNED = 1'b1;

   typedef struct packed {
      logic is_unsigned;
      logic neg;
      logic dz;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0]      rem;
      logic [DIVIDEND_W-1:0] word;
      logic [DIVISOR_W-1:0]  dmag;
      side_type              side;
   } stage_type;

   typedef struct packed {
      logic [QUOT_W-1:0] quotient;
      logic              overflow;
      logic              div_by_zero;
   } res_type;

endpackage

// ----- rtl/long_division_64_by_32_unit.sv -----
// Top level of the pipelined 64-by-32 non-restoring divider.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_cmd, req_num_low, req_num_high,
//                                             req_divisor
//   rsp_      out        rsp_valid/rsp_stall  rsp_quotient, rsp_overflow,
//                                             rsp_div_by_zero
//
// The unit accepts one item per cycle while req_stall is low. Each item
// passes an input stage, a chain of 64 division cells that settle one
// quotient bit each, and an output register. The input stage is loaded at
// the edge that takes the item; its result reaches rsp_valid after it has
// passed every cell and the output register. The 64-cell chain sets the
// latency. Reset is synchronous and clears every stage valid bit and the
// output and skid valid bits. When the output is stalled, the skid register
// catches one more item; req_stall rises only once it is full, and then
// the whole chain holds its contents until the output moves again.
module long_division_64_by_32_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cmd,
   input  logic [ldiv64_pkg::DIVISOR_W-1:0] req_num_low,
   input  logic [ldiv64_pkg::DIVISOR_W-1:0] req_num_high,
   input  logic [ldiv64_pkg::DIVISOR_W-1:0] req_divisor,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ldiv64_pkg::QUOT_W-1:0]    rsp_quotient,
   output logic                             rsp_overflow,
   output logic                             rsp_div_by_zero
);

   // Chain enable: the input stage and every cell move together while the skid register is free.
   logic                  en;

   // Links between stages: entry 0 is the input stage, entry k the k-th cell.
   logic                  link_valid [ldiv64_pkg::CELLS+1];
   ldiv64_pkg::stage_type link_data  [ldiv64_pkg::CELLS+1];

   // The input stage negates signed operands to magnitudes, records the
   // quotient sign and flags a zero divisor. The partial remainder starts
   // at zero, which the first cell treats as nonnegative.
   ldiv64_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_num_low  (req_num_low),
      .req_num_high (req_num_high),
      .req_divisor  (req_divisor),
      .out_valid    (link_valid[0]),
      .out_data     (link_data[0])
   );

   // Each cell shifts one dividend bit into the partial remainder, adds or
   // subtracts the divisor by the remainder sign, and shifts the new
   // quotient bit into the low end of the same word. After all 64 cells the
   // word holds the full 64-bit quotient magnitude.
   for (genvar k = 0; k < ldiv64_pkg::CELLS; k++) begin : g_cell
      ldiv64_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (link_valid[k]),
         .in_data   (link_data[k]),
         .out_valid (link_valid[k+1]),
         .out_data  (link_data[k+1])
      );
   end

   // The output stage restores the quotient sign, keeps its low 32 bits,
   // checks the magnitude against the signed or unsigned range, and holds
   // the result in the output register with a skid register behind it.
   ldiv64_post u_post (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (link_valid[ldiv64_pkg::CELLS]),
      .in_data         (link_data[ldiv64_pkg::CELLS]),
      .en              (en),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_quotient    (rsp_quotient),
      .rsp_overflow    (rsp_overflow),
      .rsp_div_by_zero (rsp_div_by_zero)
   );

endmodule

// ----- rtl/ldiv64_prep.sv -----
// Input stage: takes operand magnitudes and the quotient sign into the first stage register.
module ldiv64_prep (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic [ldiv64_pkg::DIVISOR_W-1:0]     req_num_low,
   input  logic [ldiv64_pkg::DIVISOR_W-1:0]     req_num_high,
   input  logic [ldiv64_pkg::DIVISOR_W-1:0]     req_divisor,
   output logic                                 out_valid,
   output ldiv64_pkg::stage_type                out_data
);

   logic                              valid_ff;
   logic                              valid_in;
   ldiv64_pkg::stage_type             data_ff;
   ldiv64_pkg::stage_type             data_in;
   logic [ldiv64_pkg::DIVIDEND_W-1:0] num;
   logic                              n_neg;
   logic                              d_neg;

   assign req_stall = !en;
   assign num       = {req_num_high, req_num_low};
   assign n_neg     = (req_cmd == ldiv64_pkg::CMD_SIGNED) && req_num_high[31];
   assign d_neg     = (req_cmd == ldiv64_pkg::CMD_SIGNED) && req_divisor[31];

   always_comb begin
      data_in.rem              = '0;
      data_in.word             = n_neg ? (~num + 64'd1) : num;
      data_in.dmag             = d_neg ? (~req_divisor + 32'd1) : req_divisor;
      data_in.side.is_unsigned = (req_cmd == ldiv64_pkg::CMD_UNSIGNED);
      data_in.side.neg         = n_neg ^ d_neg;
      data_in.side.dz          = (req_divisor == '0);
      valid_in                 = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/ldiv64_cell.sv -----
// One non-restoring division cell: settles one quotient bit and passes the item on.
module ldiv64_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  ldiv64_pkg::stage_type in_data,
   output logic                  out_valid,
   output ldiv64_pkg::stage_type out_data
);

   logic                          valid_ff;
   ldiv64_pkg::stage_type         data_ff;
   ldiv64_pkg::stage_type         data_in;
   logic [ldiv64_pkg::REM_W-1:0]  shifted;
   logic [ldiv64_pkg::REM_W-1:0]  dext;
   logic [ldiv64_pkg::REM_W-1:0]  res;
   logic                          qbit;

   // Shift the next dividend bit into the partial remainder. A negative
   // remainder takes the divisor back, a nonnegative one has it removed.
   assign shifted = {in_data.rem[ldiv64_pkg::REM_W-2:0],
                     in_data.word[ldiv64_pkg::DIVIDEND_W-1]};
   assign dext    = {2'b00, in_data.dmag};
   assign res     = in_data.rem[ldiv64_pkg::REM_W-1] ? (shifted + dext)
                                                      : (shifted - dext);
   assign qbit    = !res[ldiv64_pkg::REM_W-1];

   always_comb begin
      data_in      = in_data;
      data_in.rem  = res;
      data_in.word = {in_data.word[ldiv64_pkg::DIVIDEND_W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/ldiv64_post.sv -----
// Output stage: sign correction, range check, result register and skid register.
module ldiv64_post (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  ldiv64_pkg::stage_type               in_data,
   output logic                                en,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ldiv64_pkg::QUOT_W-1:0]       rsp_quotient,
   output logic                                rsp_overflow,
   output logic                                rsp_div_by_zero
);

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   ldiv64_pkg::res_type               rsp_data_ff;
   ldiv64_pkg::res_type               rsp_data_in;
   logic                              skid_valid_ff;
   logic                              skid_valid_in;
   ldiv64_pkg::res_type               skid_data_ff;
   ldiv64_pkg::res_type               skid_data_in;
   ldiv64_pkg::res_type               fin;
   logic [ldiv64_pkg::DIVIDEND_W-1:0] q_mag;
   logic [ldiv64_pkg::QUOT_W-1:0]     q_low;
   logic                              take;

   assign q_mag = in_data.word;
   assign q_low = q_mag[ldiv64_pkg::QUOT_W-1:0];

   always_comb begin
      fin.div_by_zero = in_data.side.dz;
      if (in_data.side.dz) begin
         fin.quotient = '0;
         fin.overflow = 1'b0;
      end else if (in_data.side.is_unsigned) begin
         fin.quotient = q_low;
         fin.overflow = q_mag > ldiv64_pkg::LIM_UNSIGNED;
      end else if (in_data.side.neg) begin
         fin.quotient = ~q_low + 32'd1;
         fin.overflow = q_mag > ldiv64_pkg::LIM_SIGNED;
      end else begin
         fin.quotient = q_low;
         fin.overflow = q_mag >= ldiv64_pkg::LIM_SIGNED;
      end
   end

   assign en   = !skid_valid_ff;
   assign take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = fin;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = fin;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_quotient    = rsp_data_ff.quotient;
   assign rsp_overflow    = rsp_data_ff.overflow;
   assign rsp_div_by_zero = rsp_data_ff.div_by_zero;

   // The skid register only ever holds an item behind an occupied output.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // The skid register fills only when the output item was held back.
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid register filled without a stalled output");

   // A zero divisor always reports a cleared quotient and no overflow.
   a_zero_divisor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.div_by_zero) |->
         (rsp_data_ff.quotient == '0 && !rsp_data_ff.overflow))
      else $error("zero divisor result carries a quotient or overflow");

endmodule

// ----- dv/long_division_64_by_32_unit_test.sv -----
// Self-checking testbench for the pipelined 64-by-32 signed and unsigned divider.
`timescale 1ns / 100ps

class division_checker;
   localparam logic [63:0] FIT_UNSIGNED = (64'd1 << ldiv64_pkg::STEPS) - 64'd1;
   localparam logic [63:0] FIT_NEG      = 64'd1 << (ldiv64_pkg::STEPS - 1);

   ldiv64_pkg::res_type owed_quotients[$];
   int unsigned mismatches;
   int unsigned strays;
   int unsigned shown;
   int unsigned checked;
   int unsigned signed_items;
   int unsigned unsigned_items;
   int unsigned overflows;
   int unsigned zero_divides;

   function new();
      mismatches     = 0;
      strays         = 0;
      shown          = 0;
      checked        = 0;
      signed_items   = 0;
      unsigned_items = 0;
      overflows      = 0;
      zero_divides   = 0;
   endfunction

   // Truncating division of {hi, lo} by dv; the quotient is cut to 32 bits and the
   // overflow flag judged against the STEPS-bit range of the mode.
   function automatic ldiv64_pkg::res_type expected_division(logic cmd, logic [31:0] lo,
                                                             logic [31:0] hi,
                                                             logic [31:0] dv);
      ldiv64_pkg::res_type r;
      logic [63:0] num;
      logic [63:0] n_mag;
      logic [63:0] q_mag;
      logic [63:0] q_twos;
      logic [31:0] d_mag;
      logic        neg;
      r = '0;
      if (dv == 32'd0) begin
         r.div_by_zero = 1'b1;
         return r;
      end
      num = {hi, lo};
      if (cmd == ldiv64_pkg::CMD_UNSIGNED) begin
         q_mag      = num / {32'd0, dv};
         r.quotient = q_mag[31:0];
         r.overflow = q_mag > FIT_UNSIGNED;
      end else begin
         n_mag = hi[31] ? 64'd0 - num : num;
         d_mag = dv[31] ? 32'd0 - dv : dv;
         q_mag = n_mag / {32'd0, d_mag};
         neg   = hi[31] ^ dv[31];
         if (neg) begin
            q_twos     = 64'd0 - q_mag;
            r.quotient = q_twos[31:0];
            r.overflow = q_mag > FIT_NEG;
         end else begin
            r.quotient = q_mag[31:0];
            r.overflow = q_mag > FIT_NEG - 64'd1;
         end
      end
      return r;
   endfunction

   function void note_division(logic cmd, logic [31:0] lo, logic [31:0] hi, logic [31:0] dv);
      ldiv64_pkg::res_type r;
      r = expected_division(cmd, lo, hi, dv);
      owed_quotients.push_back(r);
      if (cmd == ldiv64_pkg::CMD_UNSIGNED) unsigned_items++;
      else signed_items++;
      if (r.overflow) overflows++;
      if (r.div_by_zero) zero_divides++;
   endfunction

   function void check_quotient(logic [31:0] quotient, logic overflow, logic div_by_zero);
      ldiv64_pkg::res_type want;
      if (owed_quotients.size() == 0) begin
         strays++;
         if (shown < 10) begin
            shown++;
            $display("%0t: result with no division pending: q=%h ovf=%b dz=%b",
                     $realtime, quotient, overflow, div_by_zero);
         end
         return;
      end
      want = owed_quotients.pop_front();
      checked++;
      if (want.quotient !== quotient || want.overflow !== overflow ||
          want.div_by_zero !== div_by_zero) begin
         mismatches++;
         if (shown < 10) begin
            shown++;
            $display("%0t: result %0d differs, expected/actual: q %h/%h ovf %b/%b dz %b/%b",
                     $realtime, checked, want.quotient, quotient, want.overflow, overflow,
                     want.div_by_zero, div_by_zero);
         end
      end
   endfunction

   function int unsigned owed_count();
      return owed_quotients.size();
   endfunction

   function int unsigned failures();
      return mismatches + strays;
   endfunction
endclass

module long_division_64_by_32_unit_test;

   // The divider presents a result once its item has passed the input stage, the 64 cells
   // and the output register; the settle time at the end is sized from that.
   localparam int DRAIN_CYCLES = 80;
   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 650;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic        req_cmd         = ldiv64_pkg::CMD_SIGNED;
   logic [31:0] req_num_low     = 32'd0;
   logic [31:0] req_num_high    = 32'd0;
   logic [31:0] req_divisor     = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [31:0] rsp_quotient;
   logic        rsp_overflow;
   logic        rsp_div_by_zero;

   // While quiet is set, neither side inserts idle cycles; it covers the tail of
   // the run so that the chain also sees a long unbroken stream.
   logic quiet  = 1'b0;
   logic steady = 1'b0;

   division_checker board = new();

   long_division_64_by_32_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_num_low     (req_num_low),
      .req_num_high    (req_num_high),
      .req_divisor     (req_divisor),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_quotient    (rsp_quotient),
      .rsp_overflow    (rsp_overflow),
      .rsp_div_by_zero (rsp_div_by_zero)
   );

   always #1 clock = ~clock;

   // Present one division at the falling edge and hold it until a rising edge
   // sees it taken. The expectation is recorded at that same edge.
   task automatic send_division(logic cmd, logic [31:0] lo, logic [31:0] hi,
                                logic [31:0] dv);
      logic taken;
      taken = 1'b0;
      @(negedge clock);
      req_valid    = 1'b1;
      req_cmd      = cmd;
      req_num_low  = lo;
      req_num_high = hi;
      req_divisor  = dv;
      while (!taken) begin
         @(posedge clock);
         if (!req_stall) begin
            taken = 1'b1;
            board.note_division(cmd, lo, hi, dv);
         end
      end
   endtask

   // Idle the request side; the payload wanders meanwhile, since it carries no
   // meaning while valid is low.
   task automatic pause_sender(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid    = 1'b0;
         req_cmd      = $urandom_range(0, 1);
         req_num_low  = $urandom;
         req_num_high = $urandom;
         req_divisor  = $urandom;
      end
   endtask

   task automatic maybe_pause();
      if (!quiet && !steady && $urandom_range(0, 4) == 0)
         pause_sender($urandom_range(1, 11));
   endtask

   // Hold off new divisions until every pending result has come back.
   task automatic drain_results();
      pause_sender(1);
      while (board.owed_count() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] corner_word();
      case ($urandom_range(0, 8))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'h0000_0002;
         3: return 32'h7FFF_FFFF;
         4: return 32'h8000_0000;
         5: return 32'h8000_0001;
         6: return 32'hFFFF_FFFE;
         7: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Most random divisions are built backwards from a chosen quotient, divisor and
   // remainder, so that in-range results and the exact range boundaries are hit
   // often. The rest are raw words, corner words and zero divisors.
   task automatic random_division();
      logic              cmd;
      int unsigned       pick;
      int unsigned       du;
      int                qi;
      longint            q;
      longint            dl;
      longint            n;
      longint unsigned   qu;
      longint unsigned   dmag;
      longint unsigned   rmag;
      logic [63:0]       num;
      logic [31:0]       dv;
      pick = $urandom_range(0, 19);
      cmd  = $urandom_range(0, 1);
      if (pick <= 12) begin
         du = $urandom >> $urandom_range(0, 31);
         if (du == 0) du = 1;
         if (cmd == ldiv64_pkg::CMD_UNSIGNED) begin
            if (pick <= 9) begin
               qu = {32'd0, $urandom};
            end else begin
               case ($urandom_range(0, 3))
                  0: qu = 64'h0000_0000_FFFF_FFFF;
                  1: qu = 64'h0000_0001_0000_0000;
                  2: qu = 64'd0;
                  default: qu = 64'h0000_0000_FFFF_FFFE;
               endcase
            end
            dv   = du;
            dmag = du;
            rmag = {$urandom, $urandom} % dmag;
            num  = qu * dmag + rmag;
         end else begin
            if (pick <= 9) begin
               qi = $urandom;
               q  = qi;
            end else begin
               case ($urandom_range(0, 3))
                  0: q = -64'sh8000_0000;
                  1: q = 64'sh7FFF_FFFF;
                  2: q = 64'sh8000_0000;
                  default: q = -64'sh8000_0001;
               endcase
            end
            dv   = $urandom_range(0, 1) ? 32'd0 - du : du;
            dl   = longint'($signed(dv));
            dmag = dl < 0 ? -dl : dl;
            rmag = {$urandom, $urandom} % dmag;
            n    = q * dl;
            if (n < 0) n = n - longint'(rmag);
            else n = n + longint'(rmag);
            num  = n;
         end
         send_division(cmd, num[31:0], num[63:32], dv);
      end else if (pick <= 15) begin
         send_division(cmd, $urandom, $urandom, $urandom);
      end else if (pick <= 18) begin
         send_division(cmd, corner_word(), corner_word(), corner_word());
      end else begin
         send_division(cmd, $urandom, $urandom, 32'd0);
      end
   endtask

   // Result side: stall in bursts of random length, with long runs of no stall,
   // and none at all once the run has gone quiet.
   initial begin
      while (reset) @(negedge clock);
      forever begin
         if (quiet) begin
            @(negedge clock);
            rsp_stall = 1'b0;
         end else if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(40, 150)) begin
               @(negedge clock);
               rsp_stall = 1'b0;
            end
         end else if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 11)) begin
               @(negedge clock);
               rsp_stall = 1'b1;
            end
         end else begin
            repeat ($urandom_range(1, 20)) begin
               @(negedge clock);
               rsp_stall = 1'b0;
            end
         end
      end
   end

   // Every result taken is compared with the oldest pending expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_quotient(rsp_quotient, rsp_overflow, rsp_div_by_zero);
   end

   // Watchdog: a long stretch with neither an item nor a result taken means the
   // block has hung.
   initial begin
      int unsigned dead_cycles;
      dead_cycles = 0;
      while (dead_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) dead_cycles = 0;
         else dead_cycles++;
      end
      $display("Timeout: nothing moved for %0d cycles, %0d results pending",
               STALL_LIMIT, board.owed_count());
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: zero divisors, the most negative dividend over minus one,
      // the exact edges of both quotient ranges and the signs of truncation.
      send_division(ldiv64_pkg::CMD_UNSIGNED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_division(ldiv64_pkg::CMD_SIGNED,   32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0000);
      send_division(ldiv64_pkg::CMD_SIGNED,   32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
      send_division(ldiv64_pkg::CMD_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
      send_division(ldiv64_pkg::CMD_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      maybe_pause();
      send_division(ldiv64_pkg::CMD_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
      send_division(ldiv64_pkg::CMD_UNSIGNED, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001);
      send_division(ldiv64_pkg::CMD_SIGNED,   32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001);
      send_division(ldiv64_pkg::CMD_SIGNED,   32'h8000_0000, 32'h0000_0000, 32'h0000_0001);
      send_division(ldiv64_pkg::CMD_SIGNED,   32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
      send_division(ldiv64_pkg::CMD_SIGNED,   32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
      maybe_pause();
      // Negative quotients must come out truncated toward zero.
      send_division(ldiv64_pkg::CMD_SIGNED,   32'hFFFF_FFF9, 32'hFFFF_FFFF, 32'h0000_0002);
      send_division(ldiv64_pkg::CMD_SIGNED,   32'h0000_0007, 32'h0000_0000, 32'hFFFF_FFFE);
      send_division(ldiv64_pkg::CMD_SIGNED,   32'hFFFF_FFF9, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_division(ldiv64_pkg::CMD_SIGNED,   32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
      send_division(ldiv64_pkg::CMD_SIGNED,   32'h0000_0000, 32'hC000_0000, 32'h8000_0000);
      send_division(ldiv64_pkg::CMD_UNSIGNED, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      send_division(ldiv64_pkg::CMD_UNSIGNED, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_division(ldiv64_pkg::CMD_SIGNED,   32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF);
      send_division(ldiv64_pkg::CMD_SIGNED,   32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_division(ldiv64_pkg::CMD_UNSIGNED, 32'h0000_0005, 32'h0000_0000, 32'h8000_0000);
      send_division(ldiv64_pkg::CMD_SIGNED,   32'h0000_0003, 32'h0000_0000, 32'hFFFF_FFFF);
      send_division(ldiv64_pkg::CMD_SIGNED,   32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
      drain_results();

      // Random part. Idle bursts come and go in stretches of fifty items, the
      // sender once waits for the pipeline to empty, and the tail runs flat out.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
         if (i == RANDOM_ITEMS / 2) drain_results();
         if (i == RANDOM_ITEMS - 90) quiet = 1'b1;
         maybe_pause();
         random_division();
      end
      @(negedge clock);
      req_valid = 1'b0;

      while (board.owed_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d divisions: %0d signed, %0d unsigned.",
               board.checked, board.signed_items, board.unsigned_items);
      $display("Of these %0d overflowed and %0d had a zero divisor.",
               board.overflows, board.zero_divides);
      if (board.failures() == 0 && board.owed_count() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d unexpected results, %0d missing",
                  board.mismatches, board.strays, board.owed_count());
         $display("Verification failed");
      end
      $finish;
   end

endmodule
